// File: hdl/key_chord_hotkey_matcher_macros.svh
// Assertion macros for the key chord hotkey matcher.
// Used by the top level; expects a clock named clk and a reset named rst.
`ifndef KEY_CHORD_HOTKEY_MATCHER_MACROS_SVH
`define KEY_CHORD_HOTKEY_MATCHER_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define KCHM_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication.
`define KCHM_ASSERT_IMPLY(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication.
`define KCHM_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: hdl/kchm_pkg.sv
// Package for the key chord hotkey matcher: codes, state type, compare result.
// No dependencies.
`default_nettype none

package kchm_pkg;

  localparam int CODE_BITS    = 16;
  localparam int BIND_BITS    = 64;
  localparam int CFG_IDX_BITS = 3;
  localparam int COUNT_BITS   = 3;
  localparam int MIDX_BITS    = 3;

  localparam logic [CFG_IDX_BITS-1:0] CFG_BINDING_COUNT = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BINDING_FIRST = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BINDING_LAST  = 3'd6;

  typedef enum logic [1:0] {
    ACT_RELEASE = 2'd0,
    ACT_PRESS   = 2'd1,
    ACT_HOLD    = 2'd2,
    ACT_OTHER   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    VERDICT_PASS     = 2'd0,
    VERDICT_CONSUMED = 2'd1,
    VERDICT_INVALID  = 2'd2
  } verdict_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SORT,
    ST_MATCH,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic eq;
    logic gt;
  } cmp_t;

endpackage

`default_nettype wire

// File: hdl/kchm_event_if.sv
// Key event channel: key code and action, valid/ready handshake.
// No dependencies.
`default_nettype none

interface kchm_event_if;
  logic        valid;
  logic        ready;
  logic [15:0] key_code;
  logic [1:0]  action;

  modport source (output valid, output key_code, output action, input ready);
  modport sink   (input valid, input key_code, input action, output ready);
endinterface

`default_nettype wire

// File: hdl/kchm_result_if.sv
// Result channel: verdict, match flag and binding index, valid/ready handshake.
// No dependencies.
`default_nettype none

interface kchm_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] verdict;
  logic       matched;
  logic [2:0] match_index;

  modport source (output valid, output verdict, output matched, output match_index,
                  input ready);
  modport sink   (input valid, input verdict, input matched, input match_index,
                  output ready);
endinterface

`default_nettype wire

// File: hdl/kchm_cfg_if.sv
// Configuration write channel: register index and write data, valid/ready.
// No dependencies.
`default_nettype none

interface kchm_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/kchm_cmp_unit.sv
// Shared magnitude/equality comparator used by every sequencer step.
// Depends on kchm_pkg.
`default_nettype none

module kchm_cmp_unit (
  input  wire logic [kchm_pkg::BIND_BITS-1:0] a,
  input  wire logic [kchm_pkg::BIND_BITS-1:0] b,
  output kchm_pkg::cmp_t                      res
);

  always_comb begin
    res.eq = (a == b);
    res.gt = (a > b);
  end

endmodule

`default_nettype wire

// File: hdl/key_chord_hotkey_matcher.sv
// Key chord hotkey matcher top level: held-key set, sort and binding match.
// Depends on kchm_pkg, the channel interfaces, kchm_cmp_unit and the macros header.
//
// Tracks up to KEY_SLOTS held key codes in descending order and matches the
// packed set against the first binding_count binding chords (at most
// NUM_BINDINGS). One event is handled at a time, every step going through a
// single shared comparator: a release scans every slot and then sorts; a press
// scans until it finds its own code (which clears the set and ends the event),
// a free slot or the last slot, then sorts and matches the bindings in order;
// a hold only matches; any other action goes straight to the result.
// The result waits in an output register, so the next event is taken while it
// is still pending. Configuration writes are always accepted and take effect
// the next cycle.
`default_nettype none
`include "key_chord_hotkey_matcher_macros.svh"

module key_chord_hotkey_matcher #(
  parameter int KEY_SLOTS    = 4,
  parameter int NUM_BINDINGS = 6
) (
  input  wire logic clk,
  input  wire logic rst,
  kchm_event_if.sink    events,
  kchm_result_if.source results,
  kchm_cfg_if.sink      cfg
);

  localparam int SIDX_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
  localparam int BIDX_W = (NUM_BINDINGS > 1) ? $clog2(NUM_BINDINGS) : 1;
  localparam int BCNT_W = $clog2(NUM_BINDINGS + 1);

  kchm_pkg::state_t state, state_next;

  logic [kchm_pkg::CODE_BITS-1:0]  held [KEY_SLOTS];
  logic [kchm_pkg::BIND_BITS-1:0]  bindings [NUM_BINDINGS];
  logic [kchm_pkg::COUNT_BITS-1:0] binding_count;

  logic [SIDX_W-1:0] slot_idx;
  logic [SIDX_W-1:0] pair_idx;
  logic [SIDX_W-1:0] pass_idx;
  logic [BCNT_W-1:0] bind_cnt;

  logic [kchm_pkg::CODE_BITS-1:0] code_r;
  logic [1:0]                     action_r;
  logic [1:0]                     verdict_r;
  logic                           matched_r;
  logic [kchm_pkg::MIDX_BITS-1:0] idx_r;

  logic                           out_valid;
  logic [1:0]                     out_verdict;
  logic                           out_matched;
  logic [kchm_pkg::MIDX_BITS-1:0] out_index;

  logic [kchm_pkg::BIND_BITS-1:0] cmp_a, cmp_b;
  kchm_pkg::cmp_t                 cmp;

  logic                           ev_ready, ev_accept, res_load, cfg_we;
  logic [kchm_pkg::BIND_BITS-1:0] packed_keys;
  logic [BCNT_W-1:0]              count_eff;
  logic                           bind_in_range;
  logic [SIDX_W-1:0]              pair_hi;
  logic                           slot_last, slot_zero, pair_last, pass_last;
  logic                           held_sorted;
  logic [kchm_pkg::CFG_IDX_BITS-1:0] cfg_bidx;

  kchm_cmp_unit u_cmp (
    .a   (cmp_a),
    .b   (cmp_b),
    .res (cmp)
  );

  // derived status
  always_comb begin
    packed_keys = '0;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      packed_keys[(KEY_SLOTS-1-i)*kchm_pkg::CODE_BITS +: kchm_pkg::CODE_BITS] = held[i];
    end
    held_sorted = 1'b1;
    for (int i = 1; i < KEY_SLOTS; i++) begin
      if (held[i-1] < held[i]) held_sorted = 1'b0;
    end
    count_eff = (binding_count > kchm_pkg::COUNT_BITS'(NUM_BINDINGS)) ?
                BCNT_W'(NUM_BINDINGS) : BCNT_W'(binding_count);
    bind_in_range = (bind_cnt < count_eff);
    pair_hi   = pair_idx + 1'b1;
    slot_last = (slot_idx == SIDX_W'(KEY_SLOTS - 1));
    slot_zero = (held[slot_idx] == '0);
    pair_last = (pair_idx == SIDX_W'(KEY_SLOTS - 2));
    pass_last = (pass_idx == SIDX_W'(KEY_SLOTS - 2));
    cfg_bidx  = cfg.index - kchm_pkg::CFG_BINDING_FIRST;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      kchm_pkg::ST_IDLE: begin
        if (events.valid) begin
          case (events.action)
            kchm_pkg::ACT_RELEASE, kchm_pkg::ACT_PRESS: state_next = kchm_pkg::ST_SCAN;
            kchm_pkg::ACT_HOLD:                         state_next = kchm_pkg::ST_MATCH;
            default:                                    state_next = kchm_pkg::ST_DONE;
          endcase
        end
      end
      kchm_pkg::ST_SCAN: begin
        if (action_r == kchm_pkg::ACT_RELEASE) begin
          if (slot_last) state_next = kchm_pkg::ST_SORT;
        end else if (cmp.eq) begin
          state_next = kchm_pkg::ST_DONE;
        end else if (slot_zero || slot_last) begin
          state_next = kchm_pkg::ST_SORT;
        end
      end
      kchm_pkg::ST_SORT: begin
        if (KEY_SLOTS == 1 || (pair_last && pass_last)) begin
          state_next = (action_r == kchm_pkg::ACT_RELEASE) ?
                       kchm_pkg::ST_DONE : kchm_pkg::ST_MATCH;
        end
      end
      kchm_pkg::ST_MATCH: begin
        if (!bind_in_range || cmp.eq) state_next = kchm_pkg::ST_DONE;
      end
      kchm_pkg::ST_DONE: begin
        if (res_load) state_next = kchm_pkg::ST_IDLE;
      end
      default: state_next = kchm_pkg::ST_IDLE;
    endcase
  end

  // control outputs and comparator operand select
  always_comb begin
    ev_ready  = (state == kchm_pkg::ST_IDLE);
    ev_accept = ev_ready && events.valid;
    res_load  = (state == kchm_pkg::ST_DONE) && (!out_valid || results.ready);
    cfg_we    = cfg.valid;
    cmp_a     = '0;
    cmp_b     = '0;
    case (state)
      kchm_pkg::ST_SCAN: begin
        cmp_a = kchm_pkg::BIND_BITS'(held[slot_idx]);
        cmp_b = kchm_pkg::BIND_BITS'(code_r);
      end
      kchm_pkg::ST_SORT: begin
        if (KEY_SLOTS > 1) begin
          cmp_a = kchm_pkg::BIND_BITS'(held[pair_hi]);
          cmp_b = kchm_pkg::BIND_BITS'(held[pair_idx]);
        end
      end
      kchm_pkg::ST_MATCH: begin
        cmp_a = bindings[bind_cnt[BIDX_W-1:0]];
        cmp_b = packed_keys;
      end
      default: begin
        cmp_a = '0;
        cmp_b = '0;
      end
    endcase
  end

  assign events.ready        = ev_ready;
  assign cfg.ready           = 1'b1;
  assign results.valid       = out_valid;
  assign results.verdict     = out_verdict;
  assign results.matched     = out_matched;
  assign results.match_index = out_index;

  // control state, held set, config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= kchm_pkg::ST_IDLE;
      held          <= '{default: '0};
      bindings      <= '{default: '0};
      binding_count <= '0;
      slot_idx      <= '0;
      pair_idx      <= '0;
      pass_idx      <= '0;
      bind_cnt      <= '0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        if (cfg.index == kchm_pkg::CFG_BINDING_COUNT) begin
          binding_count <= cfg.data[kchm_pkg::COUNT_BITS-1:0];
        end else if (cfg.index <= kchm_pkg::CFG_BINDING_LAST &&
                     cfg_bidx < kchm_pkg::CFG_IDX_BITS'(NUM_BINDINGS)) begin
          bindings[cfg_bidx[BIDX_W-1:0]] <= cfg.data;
        end
      end

      if (res_load) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        kchm_pkg::ST_IDLE: begin
          if (ev_accept) begin
            slot_idx <= '0;
            pair_idx <= '0;
            pass_idx <= '0;
            bind_cnt <= '0;
          end
        end
        kchm_pkg::ST_SCAN: begin
          if (action_r == kchm_pkg::ACT_RELEASE) begin
            if (cmp.eq) held[slot_idx] <= '0;
            slot_idx <= slot_idx + 1'b1;
          end else if (cmp.eq) begin
            held <= '{default: '0};
          end else if (slot_zero) begin
            held[slot_idx] <= code_r;
          end else begin
            slot_idx <= slot_idx + 1'b1;
          end
        end
        kchm_pkg::ST_SORT: begin
          if (KEY_SLOTS > 1) begin
            if (cmp.gt) begin
              held[pair_idx] <= held[pair_hi];
              held[pair_hi]  <= held[pair_idx];
            end
            if (pair_last) begin
              pair_idx <= '0;
              pass_idx <= pass_idx + 1'b1;
            end else begin
              pair_idx <= pair_hi;
            end
          end
        end
        kchm_pkg::ST_MATCH: begin
          if (bind_in_range && !cmp.eq) bind_cnt <= bind_cnt + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // request payload and result
  always_ff @(posedge clk) begin
    if (ev_accept) begin
      code_r    <= events.key_code;
      action_r  <= events.action;
      verdict_r <= (events.action == kchm_pkg::ACT_OTHER) ?
                   kchm_pkg::VERDICT_INVALID : kchm_pkg::VERDICT_PASS;
      matched_r <= 1'b0;
      idx_r     <= '0;
    end
    if (state == kchm_pkg::ST_SCAN && action_r == kchm_pkg::ACT_PRESS && cmp.eq) begin
      verdict_r <= kchm_pkg::VERDICT_CONSUMED;
    end
    if (state == kchm_pkg::ST_MATCH && bind_in_range && cmp.eq) begin
      verdict_r <= kchm_pkg::VERDICT_CONSUMED;
      matched_r <= 1'b1;
      idx_r     <= kchm_pkg::MIDX_BITS'(bind_cnt);
    end
    if (res_load) begin
      out_verdict <= verdict_r;
      out_matched <= matched_r;
      out_index   <= idx_r;
    end
  end

  `KCHM_ASSERT_IMPLY(a_sorted_idle, state == kchm_pkg::ST_IDLE, held_sorted, "held set not sorted at idle")
  `KCHM_ASSERT_NEXT(a_accept_busy, ev_accept, state != kchm_pkg::ST_IDLE, "accepted request left sequencer idle")
  `KCHM_ASSERT_IMPLY(a_match_bound, state == kchm_pkg::ST_MATCH, bind_cnt <= count_eff, "binding counter past count")
  `KCHM_ASSERT_IMPLY(a_match_verdict, out_valid && out_matched, out_verdict == kchm_pkg::VERDICT_CONSUMED && out_index < kchm_pkg::MIDX_BITS'(NUM_BINDINGS), "match without consumed verdict or index out of range")
  `KCHM_ASSERT_IMPLY(a_invalid_nomatch, out_valid && out_verdict == kchm_pkg::VERDICT_INVALID, !out_matched && out_index == '0, "invalid verdict carries a match")

endmodule

`default_nettype wire

// File: verif/key_chord_hotkey_matcher_tb.sv
`timescale 1ns / 100ps
// Testbench for key_chord_hotkey_matcher: directed and random key events, checked
// against a held-key set and binding predictor. Needs kchm_pkg and the kchm interfaces.
module key_chord_hotkey_matcher_tb;
  import kchm_pkg::*;

  localparam int NSLOTS        = 4;
  localparam int NBIND         = 6;
  localparam int POOL_SIZE     = 6;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 135;
  localparam logic [CFG_IDX_BITS-1:0] CFG_UNMAPPED = 3'd7;

  typedef logic [0:NSLOTS-1][CODE_BITS-1:0] key_set_t;

  typedef struct {
    verdict_t             verdict;
    logic                 matched;
    logic [MIDX_BITS-1:0] match_index;
  } verdict_rec_t;

  logic clk;
  logic rst;

  kchm_event_if  ev_ch();
  kchm_result_if res_ch();
  kchm_cfg_if    cfg_ch();

  key_chord_hotkey_matcher #(
    .KEY_SLOTS(NSLOTS),
    .NUM_BINDINGS(NBIND)
  ) dut (
    .clk(clk),
    .rst(rst),
    .events(ev_ch),
    .results(res_ch),
    .cfg(cfg_ch)
  );

  key_set_t              held_set;
  logic [COUNT_BITS-1:0] bind_count;
  logic [BIND_BITS-1:0]  bind_chord [NBIND];
  logic [BIND_BITS-1:0]  chord_plan [NBIND];
  logic [CODE_BITS-1:0]  code_pool [POOL_SIZE];
  verdict_rec_t          expected_verdicts [$];
  logic                  idle_on = 1'b1;
  int                    errors = 0;
  int                    result_count = 0;
  int                    cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d requests open", cycle_count,
               expected_verdicts.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic key_set_t sort_desc_set(key_set_t s);
    logic [CODE_BITS-1:0] t;
    for (int i = 0; i < NSLOTS - 1; i++)
      for (int j = 0; j < NSLOTS - 1 - i; j++)
        if (s[j] < s[j+1]) begin
          t = s[j];
          s[j] = s[j+1];
          s[j+1] = t;
        end
    return s;
  endfunction

  function automatic logic [BIND_BITS-1:0] chord_of(logic [CODE_BITS-1:0] a,
      logic [CODE_BITS-1:0] b, logic [CODE_BITS-1:0] c, logic [CODE_BITS-1:0] d);
    return sort_desc_set({a, b, c, d});
  endfunction

  function automatic logic is_held(logic [CODE_BITS-1:0] code);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < NSLOTS; i++)
      if (held_set[i] == code) hit = 1'b1;
    return hit;
  endfunction

  // Updates the held set and returns the verdict for one key event.
  function automatic verdict_rec_t match_key_event(logic [CODE_BITS-1:0] code, action_t act);
    verdict_rec_t r;
    logic         cleared;
    logic         placed;
    int           limit;
    r.verdict = VERDICT_PASS;
    r.matched = 1'b0;
    r.match_index = '0;
    cleared = 1'b0;
    placed = 1'b0;
    if (act == ACT_RELEASE) begin
      for (int i = 0; i < NSLOTS; i++)
        if (held_set[i] == code) held_set[i] = '0;
      held_set = sort_desc_set(held_set);
    end else if (act == ACT_OTHER) begin
      r.verdict = VERDICT_INVALID;
    end else begin
      if (act == ACT_PRESS) begin
        // equality is tested before emptiness, so code zero hits an empty slot
        for (int i = 0; i < NSLOTS; i++)
          if (!placed && !cleared) begin
            if (held_set[i] == code) begin
              cleared = 1'b1;
            end else if (held_set[i] == '0) begin
              held_set[i] = code;
              placed = 1'b1;
            end
          end
        if (cleared) held_set = '0;
        else held_set = sort_desc_set(held_set);
      end
      if (cleared) begin
        r.verdict = VERDICT_CONSUMED;
      end else begin
        limit = (int'(bind_count) > NBIND) ? NBIND : int'(bind_count);
        for (int k = 0; k < NBIND; k++)
          if (!r.matched && k < limit && bind_chord[k] == held_set) begin
            r.verdict = VERDICT_CONSUMED;
            r.matched = 1'b1;
            r.match_index = MIDX_BITS'(k);
          end
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("ERROR result %0d %s: got %0h expected %0h", result_count, field, got, want);
    errors++;
  endtask

  task automatic check_result();
    verdict_rec_t want;
    result_count++;
    if (expected_verdicts.size() == 0) begin
      report_mismatch("no request pending", 64'(res_ch.verdict), 0);
    end else begin
      want = expected_verdicts.pop_front();
      if (res_ch.verdict !== want.verdict)
        report_mismatch("verdict", 64'(res_ch.verdict), 64'(want.verdict));
      if (res_ch.matched !== want.matched)
        report_mismatch("matched", 64'(res_ch.matched), 64'(want.matched));
      if (res_ch.match_index !== want.match_index)
        report_mismatch("match_index", 64'(res_ch.match_index), 64'(want.match_index));
    end
  endtask

  initial begin : result_sink
    int stall;
    res_ch.ready = 1'b0;
    forever begin
      stall = idle_on ? $urandom_range(0, 11) : 0;
      @(negedge clk);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (rst || res_ch.valid !== 1'b1);
      check_result();
    end
  end

  task automatic send_event(logic [CODE_BITS-1:0] code, action_t act);
    int gap;
    gap = idle_on ? $urandom_range(0, 11) : 0;
    @(negedge clk);
    if (gap > 0) begin
      ev_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    ev_ch.valid    <= 1'b1;
    ev_ch.key_code <= code;
    ev_ch.action   <= act;
    do @(posedge clk); while (ev_ch.ready !== 1'b1);
    expected_verdicts.push_back(match_key_event(code, act));
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [BIND_BITS-1:0] data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    if (idx == CFG_BINDING_COUNT)
      bind_count = data[COUNT_BITS-1:0];
    else if (idx >= CFG_BINDING_FIRST && idx <= CFG_BINDING_LAST)
      bind_chord[idx - CFG_BINDING_FIRST] = data;
  endtask

  task automatic drain_requests();
    @(negedge clk);
    ev_ch.valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
  endtask

  // Registers change only with the request pipe empty.
  task automatic load_plan(logic [BIND_BITS-1:0] count_word, logic poke_unmapped);
    drain_requests();
    for (int k = 0; k < NBIND; k++)
      write_reg(CFG_BINDING_FIRST + CFG_IDX_BITS'(k), chord_plan[k]);
    write_reg(CFG_BINDING_COUNT, count_word);
    if (poke_unmapped) write_reg(CFG_UNMAPPED, '1);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_event(16'h0000, ACT_HOLD);
    send_event(16'hFFFF, ACT_OTHER);
    send_event(16'h0000, ACT_RELEASE);
  endtask

  task automatic test_chord_build();
    chord_plan[0] = chord_of(16'hFFFF, 16'h0038, 16'h001D, 16'h0000);
    chord_plan[1] = chord_of(16'hFFFF, 16'h0038, 16'h001D, 16'h0001);
    chord_plan[2] = '0;
    chord_plan[3] = chord_of(16'h0038, 16'h0000, 16'h0000, 16'h0000);
    chord_plan[4] = 64'h5555_AAAA_0F0F_F0F0;
    chord_plan[5] = chord_of(16'h001D, 16'h0000, 16'h0000, 16'h0000);
    load_plan(64'd3, 1'b0);
    send_event(16'h001D, ACT_PRESS);
    send_event(16'h0038, ACT_PRESS);
    send_event(16'hFFFF, ACT_PRESS);
    send_event(16'h0001, ACT_PRESS);
    send_event(16'h0002, ACT_PRESS);
    send_event(16'h1234, ACT_HOLD);
    send_event(16'h0038, ACT_RELEASE);
    send_event(16'h0000, ACT_HOLD);
    send_event(16'h001D, ACT_PRESS);
    send_event(16'h0000, ACT_HOLD);
    send_event(16'h0000, ACT_PRESS);
  endtask

  task automatic test_zero_and_full();
    send_event(16'h8000, ACT_PRESS);
    send_event(16'h4000, ACT_PRESS);
    send_event(16'h0F00, ACT_PRESS);
    send_event(16'h00FF, ACT_PRESS);
    send_event(16'h0000, ACT_PRESS);
    send_event(16'h0000, ACT_RELEASE);
    send_event(16'h4000, ACT_RELEASE);
    send_event(16'h0000, ACT_PRESS);
  endtask

  task automatic test_count_limits();
    for (int k = 0; k < 4; k++) chord_plan[k] = {$urandom, $urandom};
    chord_plan[4] = '1;
    chord_plan[5] = '0;
    load_plan(64'd7, 1'b0);
    send_event(16'hFFFF, ACT_HOLD);
    load_plan(64'd5, 1'b0);
    send_event(16'h0000, ACT_HOLD);
    load_plan(64'd6, 1'b1);
    send_event(16'h0000, ACT_HOLD);
    load_plan(64'd0, 1'b0);
    send_event(16'hFFFF, ACT_HOLD);
  endtask

  function automatic logic [BIND_BITS-1:0] random_pool_chord();
    key_set_t s;
    int       n;
    s = '0;
    n = $urandom_range(1, NSLOTS);
    for (int i = 0; i < n; i++) s[i] = code_pool[$urandom_range(0, POOL_SIZE - 1)];
    return sort_desc_set(s);
  endfunction

  task automatic send_random_event();
    int                   roll;
    logic [CODE_BITS-1:0] code;
    roll = $urandom_range(0, 99);
    code = code_pool[$urandom_range(0, POOL_SIZE - 1)];
    if (roll < 38) begin
      if (is_held(code) && $urandom_range(0, 3) != 0)
        code = code_pool[$urandom_range(0, POOL_SIZE - 1)];
      send_event(code, ACT_PRESS);
    end else if (roll < 60) begin
      send_event(CODE_BITS'($urandom), ACT_HOLD);
    end else if (roll < 84) begin
      if ($urandom_range(0, 3) != 0) code = held_set[$urandom_range(0, NSLOTS - 1)];
      send_event(code, ACT_RELEASE);
    end else if (roll < 92) begin
      send_event(CODE_BITS'($urandom), action_t'($urandom_range(0, 3)));
    end else if (roll < 96) begin
      send_event('0, ACT_PRESS);
    end else begin
      send_event(CODE_BITS'($urandom), ACT_OTHER);
    end
  endtask

  task automatic test_random_sessions();
    logic [BIND_BITS-1:0] count_word;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      for (int p = 0; p < POOL_SIZE; p++)
        code_pool[p] = CODE_BITS'($urandom_range(1, 65535));
      for (int k = 0; k < NBIND; k++)
        if ($urandom_range(0, 5) == 0) chord_plan[k] = {$urandom, $urandom};
        else chord_plan[k] = random_pool_chord();
      count_word = {$urandom, $urandom};
      case (ph)
        0: count_word[COUNT_BITS-1:0] = 3'd0;
        1: count_word[COUNT_BITS-1:0] = 3'd7;
        2: count_word[COUNT_BITS-1:0] = 3'd6;
        3: count_word[COUNT_BITS-1:0] = 3'd1;
        default: count_word[COUNT_BITS-1:0] = COUNT_BITS'($urandom_range(0, 7));
      endcase
      load_plan(count_word, ph == 4);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 35 == 0) idle_on = ($urandom_range(0, 3) != 0);
        send_random_event();
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    rst = 1'b1;
    ev_ch.valid = 1'b0;
    ev_ch.key_code = '0;
    ev_ch.action = ACT_RELEASE;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    held_set = '0;
    bind_count = '0;
    for (int k = 0; k < NBIND; k++) bind_chord[k] = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_chord_build();
    test_zero_and_full();
    test_count_limits();
    test_random_sessions();

    drain_requests();
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
